### hw/rtl/lss_pkg.sv
package lss_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 7;
  localparam int COUNT_W   = 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SEARCH
  } fsm_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] top_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rot;
  } cell_ctrl_t;

endpackage

### hw/rtl/lss_cell.sv
module lss_cell (
  input  logic                      clk,
  input  lss_pkg::cell_ctrl_t       ctrl,
  input  logic                      wrap_en,
  input  logic [lss_pkg::WORD_W-1:0] up_word,
  input  logic [lss_pkg::WORD_W-1:0] dn_word,
  input  logic [lss_pkg::WORD_W-1:0] wrap_word,
  output logic [lss_pkg::WORD_W-1:0] word
);
  import lss_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.push) begin
      word_nxt = up_word;
    end else if (ctrl.pop) begin
      word_nxt = dn_word;
    end else if (ctrl.rot) begin
      word_nxt = wrap_en ? wrap_word : dn_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

### hw/rtl/lifo_stack_with_search.sv
// LIFO stack of DEPTH signed 32-bit words held in a chain of cells, cell 0
// being the top. Push, pop and clear run back to back, one transfer per cycle
// while the output register can take a result; push and pop shift the whole
// chain down or up in a single step, and clear only resets the fill count.
// A search on a stack holding N entries rotates the chain one place per cycle
// past the comparator at the top cell, the last step waiting on a stalled
// result, and leaves it in its original order. A search on an empty stack
// reports not found without rotating. Every result is held in an output
// register; a new item is taken only when that register is empty or its
// result transfers in the same cycle, and not while a search runs.
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lss_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lss_pkg::out_item_t out_data
);
  import lss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  fsm_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [WORD_W-1:0] top_save_r, top_save_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic [WORD_W-1:0] words [DEPTH];
  logic [CW-1:0] fill_last;
  cell_ctrl_t    ctrl;
  logic          in_xfer, out_free, is_full_now, is_empty_now;
  logic          last_step, step_en, match;
  logic          load_res;
  status_t       res_status;
  logic [WORD_W-1:0] res_popped, res_top;
  logic [IW-1:0] res_pos;

  assign out_free     = ~out_valid_r | ~out_stall;
  assign in_stall     = (state_r != FSM_IDLE) | ~out_free;
  assign in_xfer      = in_valid & ~in_stall;
  assign fill_last    = fill_r - CW'(1);
  assign is_full_now  = (fill_r == CW'(DEPTH));
  assign is_empty_now = (fill_r == '0);
  assign last_step    = (CW'(cnt_r) == fill_last);
  assign step_en      = ~last_step | out_free;
  assign match        = (words[0] == key_r);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] up_w, dn_w;
    if (k == 0) begin : g_first
      assign up_w = in_data.value;
    end else begin : g_mid
      assign up_w = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign dn_w = words[0];
    end else begin : g_inner
      assign dn_w = words[k+1];
    end
    lss_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wrap_en   (fill_last == CW'(k)),
      .up_word   (up_w),
      .dn_word   (dn_w),
      .wrap_word (words[0]),
      .word      (words[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_xfer && in_data.func == OP_SEARCH && !is_empty_now) begin
          state_nxt = FSM_SEARCH;
        end
      end
      FSM_SEARCH: begin
        if (last_step && step_en) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    load_res     = 1'b0;
    res_status   = ST_OK;
    res_popped   = '0;
    res_pos      = '0;
    res_top      = is_empty_now ? '0 : words[0];
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    key_nxt      = key_r;
    top_save_nxt = top_save_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_xfer) begin
          case (in_data.func)
            OP_PUSH: begin
              load_res = 1'b1;
              if (is_full_now) begin
                res_status = ST_OVERFLOW;
              end else begin
                ctrl.push = 1'b1;
                res_top   = in_data.value;
                fill_nxt  = fill_r + CW'(1);
              end
            end
            OP_POP: begin
              load_res = 1'b1;
              if (is_empty_now) begin
                res_status = ST_UNDERFLOW;
              end else begin
                ctrl.pop   = 1'b1;
                res_popped = words[0];
                res_top    = (fill_r == CW'(1)) ? '0 : words[1];
                fill_nxt   = fill_last;
              end
            end
            OP_SEARCH: begin
              if (is_empty_now) begin
                load_res   = 1'b1;
                res_status = ST_NOTFOUND;
              end else begin
                cnt_nxt      = '0;
                found_nxt    = 1'b0;
                pos_nxt      = '0;
                key_nxt      = in_data.value;
                top_save_nxt = words[0];
              end
            end
            OP_CLEAR: begin
              load_res = 1'b1;
              res_top  = '0;
              fill_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      FSM_SEARCH: begin
        if (step_en) begin
          ctrl.rot = 1'b1;
          cnt_nxt  = cnt_r + IW'(1);
          if (!found_r && match) begin
            found_nxt = 1'b1;
            pos_nxt   = cnt_r;
          end
          if (last_step) begin
            load_res   = 1'b1;
            res_top    = top_save_r;
            res_status = (found_r || match) ? ST_OK : ST_NOTFOUND;
            res_pos    = found_r ? pos_r : (match ? cnt_r : '0);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (load_res) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = res_status;
      out_data_nxt.popped_value = res_popped;
      out_data_nxt.position     = POS_W'(res_pos);
      out_data_nxt.top_value    = res_top;
      out_data_nxt.entry_count  = COUNT_W'(fill_nxt);
      out_data_nxt.is_empty     = (fill_nxt == '0);
      out_data_nxt.is_full      = (fill_nxt == CW'(DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    top_save_r <= top_save_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/lss_checker.sv
module lss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lss_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lss_pkg::out_item_t out_data
);
  import lss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.top_value == '0 && !out_data.is_full)
    else $error("empty stack shows a top word");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_UNDERFLOW |->
      out_data.is_empty && out_data.popped_value == '0)
    else $error("underflow on a non-empty stack");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OVERFLOW |->
      out_data.is_full && out_data.popped_value == '0)
    else $error("overflow on a stack that is not full");

  a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOTFOUND |->
      out_data.position == '0 && out_data.popped_value == '0)
    else $error("failed search reports a position");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);
